FILE: hw/rtl/spike_burst_detector_unit_assert.svh
// ----------------------------------------------------------------------------
// Spike burst detector assertion macros
// Shared property macros, clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SPIKE_BURST_DETECTOR_UNIT_ASSERT_SVH
`define SPIKE_BURST_DETECTOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SBD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/sbd_pkg.sv
// ----------------------------------------------------------------------------
// Spike burst detector package
// Field widths, beat types, configuration register indexes and constants.
// ----------------------------------------------------------------------------
package sbd_pkg;

    localparam int ID_W        = 31;
    localparam int TIME_W      = 32;
    localparam int COUNT_W     = 32;
    localparam int GAP_W       = 31;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_WINDOW_START = 2'd0;
    localparam cfg_index_t CFG_WINDOW_END   = 2'd1;
    localparam cfg_index_t CFG_MAX_GAP      = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [ID_W-1:0]   spike_id;
        logic [TIME_W-1:0] spike_time;
    } spike_in_t;

    typedef struct packed {
        logic [ID_W-1:0]    first_id;
        logic [TIME_W-1:0]  first_time;
        logic [COUNT_W-1:0] spike_count;
        logic [TIME_W-1:0]  burst_length;
    } burst_out_t;

    typedef struct packed {
        logic [TIME_W-1:0] window_start;
        logic [TIME_W-1:0] window_end;
        logic [GAP_W-1:0]  max_gap;
    } cfg_t;

endpackage

FILE: hw/rtl/sbd_queue.sv
// ----------------------------------------------------------------------------
// Spike burst detector event queue
// Small first-word-fall-through queue between the front and back ends.
// ----------------------------------------------------------------------------
module sbd_queue #(
    parameter int DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_i,
    input  sbd_pkg::spike_in_t push_data_i,
    input  logic              pop_i,
    output sbd_pkg::spike_in_t pop_data_o,
    output logic              full_o,
    output logic              empty_o
);
    import sbd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    spike_in_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full_o     = (count_reg == FULL_CNT);
    assign empty_o    = (count_reg == '0);
    assign pop_data_o = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_i) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop_i) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push_i && !pop_i) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop_i && !push_i) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_i) begin
            mem_reg[wr_ptr_reg] <= push_data_i;
        end
    end

endmodule

FILE: hw/rtl/sbd_front.sv
// ----------------------------------------------------------------------------
// Spike burst detector front end
// Accepts spike beats and keeps only those inside the time window.
// ----------------------------------------------------------------------------
module sbd_front (
    input  logic               s_valid,
    output logic               s_ready,
    input  sbd_pkg::spike_in_t s_data,
    input  sbd_pkg::cfg_t      cfg_i,
    input  logic               q_full_i,
    output logic               push_o,
    output sbd_pkg::spike_in_t push_data_o
);
    import sbd_pkg::*;

    logic after_start;
    logic before_end;
    logic in_window;

    // A window end of zero leaves the window open at the top.
    assign after_start = (s_data.spike_time >= cfg_i.window_start);
    assign before_end  = (cfg_i.window_end == '0) ||
                         (s_data.spike_time <= cfg_i.window_end);
    assign in_window   = after_start && before_end;

    // Out-of-window beats are taken and dropped without touching the queue.
    assign s_ready     = !q_full_i;
    assign push_o      = s_valid && !q_full_i && in_window;
    assign push_data_o = s_data;

endmodule

FILE: hw/rtl/sbd_back.sv
// ----------------------------------------------------------------------------
// Spike burst detector back end
// Tracks the running burst and holds the finished-burst report register.
// ----------------------------------------------------------------------------
module sbd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  sbd_pkg::cfg_t       cfg_i,
    input  logic                q_empty_i,
    input  sbd_pkg::spike_in_t  q_data_i,
    output logic                pop_o,
    output logic                m_valid,
    input  logic                m_ready,
    output sbd_pkg::burst_out_t m_data
);
    import sbd_pkg::*;
    `include "spike_burst_detector_unit_assert.svh"

    logic [TIME_W-1:0]  last_time_reg, last_time_next;
    logic [ID_W-1:0]    last_id_reg, last_id_next;
    logic               bursting_reg, bursting_next;
    logic [TIME_W-1:0]  start_time_reg, start_time_next;
    logic [ID_W-1:0]    start_id_reg, start_id_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    burst_out_t         out_data_reg, out_data_next;

    logic [TIME_W-1:0]  gap;
    logic               gap_ok;
    logic               pop;

    // An event is consumed only when the report register can take a result.
    assign pop     = !q_empty_i && (!out_valid_reg || m_ready);
    assign pop_o   = pop;
    assign gap     = q_data_i.spike_time - last_time_reg;
    assign gap_ok  = (last_time_reg != '0) && (gap <= {1'b0, cfg_i.max_gap});

    always_comb begin
        last_time_next  = last_time_reg;
        last_id_next    = last_id_reg;
        bursting_next   = bursting_reg;
        start_time_next = start_time_reg;
        start_id_next   = start_id_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_data_next   = out_data_reg;
        if (pop) begin
            if (gap_ok) begin
                if (!bursting_reg) begin
                    // The previous spike opens the burst; this one is its second.
                    start_time_next = last_time_reg;
                    start_id_next   = last_id_reg;
                    count_next      = COUNT_W'(2);
                end else if (count_reg != COUNT_MAX) begin
                    count_next = count_reg + COUNT_W'(1);
                end
                bursting_next = 1'b1;
            end else if (bursting_reg) begin
                out_valid_next             = 1'b1;
                out_data_next.first_id     = start_id_reg;
                out_data_next.first_time   = start_time_reg;
                out_data_next.spike_count  = count_reg;
                out_data_next.burst_length = last_time_reg - start_time_reg;
                bursting_next              = 1'b0;
                count_next                 = '0;
            end
            last_time_next = q_data_i.spike_time;
            last_id_next   = q_data_i.spike_id;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_time_reg <= '0;
            last_id_reg   <= '0;
            bursting_reg  <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            last_time_reg <= last_time_next;
            last_id_reg   <= last_id_next;
            bursting_reg  <= bursting_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        start_time_reg <= start_time_next;
        start_id_reg   <= start_id_next;
        out_data_reg   <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    `SBD_ASSERT_IMPL(a_count_in_burst, bursting_reg, count_reg >= COUNT_W'(2), "count below two in burst")
    `SBD_ASSERT_IMPL(a_count_idle, !bursting_reg, count_reg == '0, "count nonzero outside burst")
    `SBD_ASSERT_IMPL(a_report_count, out_valid_reg, out_data_reg.spike_count >= COUNT_W'(2), "short burst reported")
    `SBD_ASSERT_NEXT(a_report_closes, pop && !gap_ok && bursting_reg, !bursting_reg && out_valid_reg, "burst end not reported")

endmodule

FILE: hw/rtl/spike_burst_detector_unit.sv
// ----------------------------------------------------------------------------
// Spike burst detector
// Maximum-interval burst detection on a stream of timestamped spike beats.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Beat contents
//   s_        in          spike_id (31 b), spike_time (32 b)
//   m_        out         first_id, first_time, spike_count, burst_length
//   cfg_      in          write enable, register index, 32-bit write data
//
// The block accepts one spike beat per cycle while the queue is not full.
// A report is registered in the output register once the beat that ends
// the burst has passed through the queue and been popped by the back end.
// Sustained rate is one beat per cycle while m_ready keeps up, set by the
// gap compare and count update that the back end does for each pop.
// Reset is synchronous and active low; it clears the burst state and the
// queue at once, with no clearing pass.
// A stalled m_ready holds the report; the queue keeps taking beats until it
// is full, and s_ready drops only then.
//
// The front end checks each beat against the time window and drops those
// outside it. Beats inside the window go through a short queue to the back
// end, which follows the current burst. A burst is a run of spikes whose
// gaps to the spike before are at most max_gap; it is reported only when a
// later in-window spike breaks the run, so an open burst is never flushed.
// A previous time of zero means there is no previous spike.
//
module spike_burst_detector_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  sbd_pkg::spike_in_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output sbd_pkg::burst_out_t               m_data,
    input  logic                              cfg_wr_en,
    input  sbd_pkg::cfg_index_t               cfg_index,
    input  logic [sbd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import sbd_pkg::*;

    // Configuration registers. Writes to an unused index are ignored.
    cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_WINDOW_START: cfg_next.window_start = cfg_wdata[TIME_W-1:0];
                CFG_WINDOW_END:   cfg_next.window_end   = cfg_wdata[TIME_W-1:0];
                CFG_MAX_GAP:      cfg_next.max_gap      = cfg_wdata[GAP_W-1:0];
                default:          cfg_next              = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    logic      q_push;
    spike_in_t q_push_data;
    logic      q_pop;
    spike_in_t q_pop_data;
    logic      q_full;
    logic      q_empty;

    // Window classification of incoming beats.
    sbd_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .cfg_i       (cfg_reg),
        .q_full_i    (q_full),
        .push_o      (q_push),
        .push_data_o (q_push_data)
    );

    // Decouples window checking from burst tracking so each side stalls alone.
    sbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_i      (q_push),
        .push_data_i (q_push_data),
        .pop_i       (q_pop),
        .pop_data_o  (q_pop_data),
        .full_o      (q_full),
        .empty_o     (q_empty)
    );

    // Burst tracking and the report register.
    sbd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_i     (cfg_reg),
        .q_empty_i (q_empty),
        .q_data_i  (q_pop_data),
        .pop_o     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
